// ===== sv/frt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants of the fragment reassembly tracker
// Table geometry, status codes and the controller state type.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int SLOTS        = 8;
    localparam int MAX_FRAGS    = 64;
    localparam int HEADER_BYTES = 20;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int IDX_W        = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int TOT_W        = $clog2(MAX_FRAGS + 1);

    localparam logic [3:0] ST_SHORT    = 4'd0;
    localparam logic [3:0] ST_BADIDX   = 4'd1;
    localparam logic [3:0] ST_MISMATCH = 4'd2;
    localparam logic [3:0] ST_FULL     = 4'd3;
    localparam logic [3:0] ST_TOOMANY  = 4'd4;
    localparam logic [3:0] ST_DUP      = 4'd5;
    localparam logic [3:0] ST_STORED   = 4'd6;
    localparam logic [3:0] ST_DONE     = 4'd7;
    localparam logic [3:0] ST_SWEPT    = 4'd8;

    localparam logic OP_FRAG  = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_READ,
        S_DECIDE,
        S_SWEEP,
        S_OUT
    } state_t;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [31:0]          seq;
        logic [TOT_W-1:0]     total;
        logic [63:0]          capture_us;
        logic [31:0]          first_tick;
        logic [TOT_W-1:0]     received;
        logic [MAX_FRAGS-1:0] mask;
    } entry_t;

endpackage
`default_nettype wire

// ===== sv/fragment_reassembly_tracker.sv =====
`default_nettype none
// Fragment item: tag search, entry memory read, decide and write back, output,
// each in its own state. A header rejected by the pre-checks skips read and
// decide. Sweep: one entry memory read per slot, then output. One item at a
// time; the next input beat is taken in the cycle after the result beat leaves.
// Reset clears valid bits, stale counter and control and sets the timeout to
// 500; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks pending frames by sequence number in a small table; reports stored,
// complete, rejected and stale-swept fragments.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // op, packet_length, frame_seq, frag_index, frag_total, capture_time_us,
    // now_ticks (low to high), zero padded
    input  wire logic [175:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, slot, store_index, done_seq, done_capture_us, pending_frames,
    // swept_now, stale_total (low to high), zero padded
    output logic [151:0]      m_tdata
);

    localparam int SW = frt_pkg::SLOT_W;
    localparam int CW = frt_pkg::CNT_W;
    localparam int TW = frt_pkg::TOT_W;
    localparam int IW = frt_pkg::IDX_W;

    frt_pkg::state_t state_reg, state_next;

    // input item registers
    logic        op_reg;
    logic [10:0] plen_reg;
    logic [31:0] seq_reg;
    logic [15:0] idx_reg;
    logic [15:0] tot_reg;
    logic [63:0] cap_reg;
    logic [31:0] now_reg;

    logic [15:0] timeout_reg;
    logic [31:0] stale_reg;
    logic [frt_pkg::SLOTS-1:0] valid_reg;
    logic [31:0] tag_mem [frt_pkg::SLOTS];  // seq per slot, fixed-place compare
    frt_pkg::entry_t entry_mem [frt_pkg::SLOTS];
    frt_pkg::entry_t rd_reg;

    logic          found_reg, free_ok_reg;
    logic [SW-1:0] slot_reg;
    logic [SW-1:0] sw_ptr_reg;
    logic [CW-1:0] swept_reg;

    // result registers
    logic [3:0]  o_status_reg;
    logic [SW-1:0] o_slot_reg;
    logic [5:0]  o_idx_reg;
    logic [31:0] o_dseq_reg;
    logic [63:0] o_dcap_reg;

    // tag search: first matching valid slot, lowest free slot
    logic          hit;
    logic [SW-1:0] hit_slot;
    logic          has_free;
    logic [SW-1:0] free_slot;
    always_comb
    begin
        hit = 1'b0;
        hit_slot = '0;
        has_free = 1'b0;
        free_slot = '0;
        for (int i = frt_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_mem[i] == seq_reg)
            begin
                hit = 1'b1;
                hit_slot = SW'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // pre-checks on header
    logic pre_reject;
    logic [3:0] pre_status;
    always_comb
    begin
        pre_reject = 1'b1;
        pre_status = frt_pkg::ST_SHORT;
        priority if (plen_reg < 11'(frt_pkg::HEADER_BYTES))
            pre_status = frt_pkg::ST_SHORT;
        else if (tot_reg == '0 || idx_reg >= tot_reg)
            pre_status = frt_pkg::ST_BADIDX;
        else if (tot_reg > 16'(frt_pkg::MAX_FRAGS))
            pre_status = frt_pkg::ST_TOOMANY;
        else
            pre_reject = 1'b0;
    end

    // decision on read entry
    logic [IW-1:0] fidx;
    assign fidx = idx_reg[IW-1:0];
    logic [TW-1:0] tot_n;
    assign tot_n = tot_reg[TW-1:0];
    frt_pkg::entry_t upd;
    logic [3:0] dec_status;
    logic dec_write, dec_done;
    always_comb
    begin
        upd = rd_reg;
        dec_write = 1'b0;
        dec_done = 1'b0;
        if (!found_reg)
        begin
            upd.seq = seq_reg;
            upd.total = tot_n;
            upd.capture_us = cap_reg;
            upd.first_tick = now_reg;
            upd.received = '0;
            upd.mask = '0;
        end
        upd.mask[fidx] = 1'b1;
        upd.received = upd.received + TW'(1);
        priority if (!found_reg && !free_ok_reg)
            dec_status = frt_pkg::ST_FULL;
        else if (found_reg && rd_reg.total != tot_n)
            dec_status = frt_pkg::ST_MISMATCH;
        else if (found_reg && rd_reg.mask[fidx])
            dec_status = frt_pkg::ST_DUP;
        else
        begin
            dec_write = 1'b1;
            dec_done = (upd.received == upd.total);
            dec_status = dec_done ? frt_pkg::ST_DONE : frt_pkg::ST_STORED;
        end
    end

    logic stale_hit;
    assign stale_hit = valid_reg[sw_ptr_reg]
        && (now_reg - rd_reg.first_tick) >= {16'd0, timeout_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frt_pkg::S_IDLE:   if (s_tvalid) state_next = frt_pkg::S_LOOK;
            frt_pkg::S_LOOK:
                if (op_reg == frt_pkg::OP_SWEEP) state_next = frt_pkg::S_SWEEP;
                else if (pre_reject) state_next = frt_pkg::S_OUT;
                else state_next = frt_pkg::S_READ;
            frt_pkg::S_READ:   state_next = frt_pkg::S_DECIDE;
            frt_pkg::S_DECIDE: state_next = frt_pkg::S_OUT;
            frt_pkg::S_SWEEP:
                if (sw_ptr_reg == SW'(frt_pkg::SLOTS - 1)) state_next = frt_pkg::S_OUT;
            frt_pkg::S_OUT:    if (m_tready) state_next = frt_pkg::S_IDLE;
            default:           state_next = frt_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == frt_pkg::S_IDLE);
        m_tvalid = (state_reg == frt_pkg::S_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= frt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // config, valid bits, stale counter, sweep pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd500;
            stale_reg <= '0;
            valid_reg <= '0;
            sw_ptr_reg <= '0;
            swept_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            if (state_reg == frt_pkg::S_LOOK)
            begin
                sw_ptr_reg <= '0;
                swept_reg <= '0;
            end
            if (state_reg == frt_pkg::S_SWEEP)
            begin
                sw_ptr_reg <= sw_ptr_reg + SW'(1);
                if (stale_hit)
                begin
                    valid_reg[sw_ptr_reg] <= 1'b0;
                    stale_reg <= stale_reg + 32'd1;
                    swept_reg <= swept_reg + CW'(1);
                end
            end
            if (state_reg == frt_pkg::S_DECIDE && dec_write)
                valid_reg[slot_reg] <= !dec_done;
        end
    end

    // entry memory: registered read, write back on decide
    logic [SW-1:0] rd_addr;
    assign rd_addr = (state_reg == frt_pkg::S_SWEEP || state_reg == frt_pkg::S_LOOK)
                     ? (state_reg == frt_pkg::S_LOOK ? SW'(0) : sw_ptr_reg + SW'(1))
                     : slot_reg;
    always_ff @(posedge clk)
    begin
        rd_reg <= entry_mem[rd_addr];
        if (state_reg == frt_pkg::S_DECIDE && dec_write)
        begin
            entry_mem[slot_reg] <= upd;
            tag_mem[slot_reg] <= upd.seq;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == frt_pkg::S_IDLE && s_tvalid)
        begin
            op_reg   <= s_tdata[0];
            plen_reg <= s_tdata[11:1];
            seq_reg  <= s_tdata[43:12];
            idx_reg  <= s_tdata[59:44];
            tot_reg  <= s_tdata[75:60];
            cap_reg  <= s_tdata[139:76];
            now_reg  <= s_tdata[171:140];
        end
        if (state_reg == frt_pkg::S_LOOK)
        begin
            found_reg <= hit;
            free_ok_reg <= has_free;
            slot_reg <= hit ? hit_slot : free_slot;
            o_status_reg <= (op_reg == frt_pkg::OP_SWEEP) ? frt_pkg::ST_SWEPT : pre_status;
            o_slot_reg <= '0;
            o_idx_reg <= '0;
            o_dseq_reg <= '0;
            o_dcap_reg <= '0;
        end
        if (state_reg == frt_pkg::S_DECIDE)
        begin
            o_status_reg <= dec_status;
            if (dec_write)
            begin
                o_slot_reg <= slot_reg;
                o_idx_reg <= 6'(fidx);
            end
            if (dec_done)
            begin
                o_dseq_reg <= upd.seq;
                o_dcap_reg <= upd.capture_us;
            end
        end
    end

    logic [CW-1:0] pending;
    always_comb
    begin
        pending = '0;
        for (int i = 0; i < frt_pkg::SLOTS; i++)
            pending = pending + CW'(valid_reg[i]);
    end

    assign m_tdata = {3'd0, stale_reg, 4'(swept_reg), 4'(pending), o_dcap_reg,
                      o_dseq_reg, o_idx_reg, 3'(o_slot_reg), o_status_reg};

endmodule
`default_nettype wire
